>>> design/coti_pkg.sv
package coti_pkg;

    localparam int COUNTER_BITS = 11;
    localparam int HIT_BITS     = 13;
    localparam int RECOV_BITS   = 3;
    localparam int FAIL_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = HIT_BITS;

    typedef logic [COUNTER_BITS-1:0] t_coarse;
    typedef logic [HIT_BITS-1:0]     t_hit;
    typedef logic [RECOV_BITS-1:0]   t_recov;
    typedef logic [FAIL_BITS-1:0]    t_fail;

    localparam t_coarse COARSE_ONE  = t_coarse'(1);
    localparam t_coarse COARSE_TWO  = t_coarse'(2);

    localparam t_recov RECOVERY_EVENTS_RST = t_recov'(3);
    localparam t_fail  FAIL_LIMIT_RST      = t_fail'(10);
    localparam t_hit   CORRECT_MASK_RST    = t_hit'(2047);

    typedef enum logic {
        CMD_EVENT   = 1'b0,
        CMD_CORRECT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RECOVERY_EVENTS = 2'd0,
        CFG_FAIL_LIMIT      = 2'd1,
        CFG_CORRECT_MASK    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_recov recovery_events;
        t_fail  fail_limit;
        t_hit   correct_mask;
    } t_cfg;

    typedef struct packed {
        t_cmd    cmd;
        logic    readout_failure;
        logic    pair_present;
        t_coarse trig_coarse;
        t_coarse ref_coarse;
        t_hit    hit_coarse;
        t_coarse extra_offset;
    } t_in_item;

    typedef struct packed {
        t_coarse offset_low;
        t_coarse offset_high;
        logic    tracking;
        logic    event_skipped;
        logic    track_failed;
        logic    fatal;
        t_hit    corrected_coarse;
    } t_out_item;

endpackage

>>> design/coarse_offset_tracker_unit.sv
// Channel   Signals                                   Dir  Moves
// in        i_in_valid / o_in_ready / i_in_item       in   one event or correct item
// out       o_out_valid / i_out_ready / o_out_item    out  one result item per input item
// cfg       i_cfg_wr_en / i_cfg_index / i_cfg_wr_data in   register write, no wait
//
// One item per cycle unless the output stalls; input register, then result register.
// The tracking window and counters update in the cycle an item leaves the input register.
// Reset (synchronous, active low) clears the window to all ones and all counters and flags,
// and loads the register defaults.
// A stalled output holds its item; the input register still takes one more item behind it.
module coarse_offset_tracker_unit
    import coti_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wr_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      advance;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    coti_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    coti_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_window_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.tracking
        |-> t_coarse'(o_out_item.offset_high - o_out_item.offset_low) <= COARSE_TWO)
        else $error("window wider than two counts");

    a_cleared_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.tracking
        |-> (o_out_item.offset_low == '1) && (o_out_item.offset_high == '1))
        else $error("window not cleared while not tracking");

    a_skip_or_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.event_skipped && o_out_item.track_failed))
        else $error("skipped item also flagged as failed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

>>> design/coti_cfg.sv
module coti_cfg
    import coti_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wr_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.recovery_events <= RECOVERY_EVENTS_RST;
            r_cfg.fail_limit      <= FAIL_LIMIT_RST;
            r_cfg.correct_mask    <= CORRECT_MASK_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RECOVERY_EVENTS: begin
                    r_cfg.recovery_events <= i_cfg_wr_data[RECOV_BITS-1:0];
                end
                CFG_FAIL_LIMIT: begin
                    r_cfg.fail_limit <= i_cfg_wr_data[FAIL_BITS-1:0];
                end
                CFG_CORRECT_MASK: begin
                    r_cfg.correct_mask <= i_cfg_wr_data[HIT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/coti_core.sv
module coti_core
    import coti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_coarse r_low, n_low;
    t_coarse r_high, n_high;
    logic    r_started, n_started;
    t_recov  r_skip, n_skip;
    t_fail   r_fail_cnt, n_fail_cnt;
    logic    r_fatal, n_fatal;

    t_coarse d;
    logic    skipped;
    logic    failed;
    t_hit    corrected;

    assign d = i_item.ref_coarse - i_item.trig_coarse;

    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_started  = r_started;
        n_skip     = r_skip;
        n_fail_cnt = r_fail_cnt;
        n_fatal    = r_fatal;
        skipped    = 1'b0;
        failed     = 1'b0;
        corrected  = '0;

        if (i_item.cmd == CMD_CORRECT) begin
            // cleared window adds 2047, i.e. minus one mod 2048 when the mask keeps 11 bits
            corrected = i_cfg.correct_mask
                      & (i_item.hit_coarse + t_hit'(r_low) + t_hit'(i_item.extra_offset));
        end else begin
            if (i_item.readout_failure) begin
                n_low     = '1;
                n_high    = '1;
                n_started = 1'b0;
                n_skip    = i_cfg.recovery_events;
            end
            if (n_skip != '0) begin
                n_skip  = n_skip - t_recov'(1);
                skipped = 1'b1;
            end else if (i_item.pair_present) begin
                if (!n_started) begin
                    n_low     = d;
                    n_high    = d;
                    n_started = 1'b1;
                end else if (d == n_high) begin
                    // inside window at the high edge, nothing moves
                end else if (d + COARSE_ONE == n_high) begin
                    if (n_low == n_high)
                        n_low = n_high - COARSE_ONE;
                end else if (d + COARSE_TWO == n_high) begin
                    if (n_low + COARSE_TWO != n_high)
                        n_low = n_high - COARSE_TWO;
                end else if (d == n_low + COARSE_ONE) begin
                    if (n_low == n_high)
                        n_high = n_low + COARSE_ONE;
                end else if (d == n_low + COARSE_TWO) begin
                    if (n_low + COARSE_TWO != n_high)
                        n_high = n_low + COARSE_TWO;
                end else begin
                    failed = 1'b1;
                end
                if (failed) begin
                    if (r_fail_cnt != '1)
                        n_fail_cnt = r_fail_cnt + t_fail'(1);
                    if (n_fail_cnt > i_cfg.fail_limit)
                        n_fatal = 1'b1;
                end
            end
        end

        o_result.offset_low       = n_low;
        o_result.offset_high      = n_high;
        o_result.tracking         = n_started;
        o_result.event_skipped    = skipped;
        o_result.track_failed     = failed;
        o_result.fatal            = n_fatal;
        o_result.corrected_coarse = corrected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= '1;
            r_high     <= '1;
            r_started  <= 1'b0;
            r_skip     <= '0;
            r_fail_cnt <= '0;
            r_fatal    <= 1'b0;
        end else if (i_step) begin
            r_low      <= n_low;
            r_high     <= n_high;
            r_started  <= n_started;
            r_skip     <= n_skip;
            r_fail_cnt <= n_fail_cnt;
            r_fatal    <= n_fatal;
        end
    end

endmodule
